// File: src/qrsd_pkg.sv
// qrsd_pkg: shared types, register indexes and the deframer step function
// for the qam receive symbol deframer; no dependencies
package qrsd_pkg;

  localparam int unsigned IqW      = 18;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned WarmW    = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned ScrW     = 17;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InTdataW = 40;
  localparam int unsigned BitsPerSym = 4;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_MAG_THRESHOLD = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_RATE_2400     = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_WARMUP        = 2'd2;

  // reset values
  localparam logic [ThrW-1:0]  THRESHOLD_RST = 17'd5325;  // 1.3 in q12
  localparam logic             RATE_RST      = 1'b1;
  localparam logic [WarmW-1:0] WARMUP_RST    = 16'd1200;
  localparam logic [CntW-1:0]  CNT_MAX       = 16'hffff;

  // descrambler taps
  localparam int unsigned TAP_A = 13;
  localparam int unsigned TAP_B = 16;

  localparam logic [BitCntW-1:0] DATA_BITS = 4'd8;

  typedef struct packed {
    logic               in_frame;
    logic [BitCntW-1:0] bit_count;
    logic [ByteW-1:0]   frame_bits;
  } dfr_state_t;

  typedef struct packed {
    dfr_state_t       st;
    logic             got;
    logic [ByteW-1:0] data;
  } dfr_res_t;

  // one bit through the start/8-data/stop deframer
  function automatic dfr_res_t dfr_step(input dfr_state_t st, input logic b);
    dfr_res_t r;
    r.st   = st;
    r.got  = 1'b0;
    r.data = st.frame_bits;
    if (!st.in_frame) begin
      if (!b) begin
        r.st.in_frame   = 1'b1;
        r.st.bit_count  = '0;
        r.st.frame_bits = '0;
      end
    end else if (st.bit_count < DATA_BITS) begin
      r.st.frame_bits[st.bit_count[2:0]] = b;
      r.st.bit_count = st.bit_count + 4'd1;
    end else begin
      r.st.in_frame = 1'b0;
      r.got         = b;
    end
    return r;
  endfunction

endpackage

// File: src/qam_rx_symbol_deframer_core.sv
// qam_rx_symbol_deframer_core: quadrant decision, differential dibit,
// descrambler and async deframer in one registered pass; uses qrsd_pkg
//
// usage
//   in_*   : one beat per integrated i/q symbol, tdata = {pad, q_sum, i_sum}
//   out_*  : one beat per received byte (only when a valid stop bit lands)
//   cfg_*  : plain register writes, only while the block is idle
// path: a taken symbol beat enters the input register; decision and
//   deframe then load its result beat into the output register
// throughput: one symbol per cycle while no byte waits on a low out_tready;
//   the symbol state (last quadrant, descrambler, deframer, symbol count)
//   is updated as the symbol leaves the input register
// reset (rst_n low, synchronous): both stages empty, state cleared, config
//   back to threshold 1.3, 2400 mode, 1200 warm-up symbols
// stall: while out_tready is low and a byte waits, the held symbol stays in
//   the input register; a second symbol is refused until the byte goes,
//   after which the pipe runs at full rate again
// at most one byte can finish per symbol since a frame spans ten bits
module qam_rx_symbol_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input symbol beat
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qrsd_pkg::InTdataW-1:0]    in_tdata,   // [17:0] i_sum, [35:18] q_sum
  // result beat
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [qrsd_pkg::ByteW-1:0]       out_tdata,  // [7:0] data_byte
  // configuration
  input  logic                             cfg_we,
  input  logic [qrsd_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [qrsd_pkg::CfgDataW-1:0]    cfg_wdata
);
  import qrsd_pkg::*;

  // config registers
  logic [ThrW-1:0]  thr_r;
  logic             rate_r;
  logic [WarmW-1:0] warm_r;

  // input register
  logic                  s1_valid_r;
  logic signed [IqW-1:0] s1_i_r, s1_q_r;

  // symbol state
  logic [1:0]     last_quad_r;
  logic           seen_r;
  logic [ScrW-1:0] scr_r;
  logic [CntW-1:0] count_r;
  dfr_state_t     dfr_r;

  // output register
  logic             out_valid_r;
  logic [ByteW-1:0] out_data_r;

  // handshake
  logic in_acc, s1_adv, out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // decision path
  logic [1:0]      quad, delta;
  logic            bit_a, bit_b, bit_c, bit_d, gt_i, gt_q, enable;
  logic [IqW-1:0]  abs_i, abs_q;
  logic [BitsPerSym-1:0] raw_bits, plain_bits;
  logic [ScrW-1:0] scr_nxt;
  logic [CntW-1:0] count_nxt;
  dfr_res_t        dfr_res;
  dfr_state_t      dfr_nxt;
  logic            got;
  logic [ByteW-1:0] got_byte;

  always_comb begin
    // quadrant: 1 and 2 above the axis, 3 and 4 below; 4 kept as 0
    if (!s1_q_r[IqW-1]) quad = s1_i_r[IqW-1] ? 2'd2 : 2'd1;
    else                quad = s1_i_r[IqW-1] ? 2'd3 : 2'd0;
    delta = quad - last_quad_r;
    bit_a = delta[1];
    bit_b = ~(delta[1] ^ delta[0]);

    // magnitudes, most negative value handled by 18-bit unsigned result
    abs_i = s1_i_r[IqW-1] ? IqW'(-s1_i_r) : IqW'(s1_i_r);
    abs_q = s1_q_r[IqW-1] ? IqW'(-s1_q_r) : IqW'(s1_q_r);
    gt_i  = abs_i > {1'b0, thr_r};
    gt_q  = abs_q > {1'b0, thr_r};
    // odd quadrants take d from |i|, even ones take c from |i|
    if (quad[0]) begin
      bit_d = gt_i;
      bit_c = gt_q;
    end else begin
      bit_c = gt_i;
      bit_d = gt_q;
    end

    // self-synchronous descrambler, a first
    raw_bits = {bit_d, bit_c, bit_b, bit_a};
    scr_nxt  = scr_r;
    for (int k = 0; k < BitsPerSym; k++) begin
      plain_bits[k] = raw_bits[k] ^ scr_nxt[TAP_A] ^ scr_nxt[TAP_B];
      scr_nxt       = {scr_nxt[ScrW-2:0], raw_bits[k]};
    end

    // deframer, two or four bits per symbol
    enable   = seen_r && (count_r >= warm_r);
    dfr_nxt  = dfr_r;
    got      = 1'b0;
    got_byte = dfr_r.frame_bits;
    for (int k = 0; k < BitsPerSym; k++) begin
      dfr_res = dfr_step(dfr_nxt, plain_bits[k]);
      if (enable && (k < 2 || rate_r)) begin
        dfr_nxt = dfr_res.st;
        if (dfr_res.got) begin
          got      = 1'b1;
          got_byte = dfr_res.data;
        end
      end
    end

    count_nxt = (count_r == CNT_MAX) ? count_r : count_r + 16'd1;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      rate_r <= RATE_RST;
      warm_r <= WARMUP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAG_THRESHOLD: thr_r  <= cfg_wdata;
        REG_RATE_2400:     rate_r <= cfg_wdata[0];
        REG_WARMUP:        warm_r <= cfg_wdata[WarmW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_i_r <= in_tdata[IqW-1:0];
      s1_q_r <= in_tdata[2*IqW-1:IqW];
    end
  end

  // symbol state, updated as the symbol leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_quad_r <= '0;
      seen_r      <= 1'b0;
      scr_r       <= '0;
      count_r     <= '0;
      dfr_r       <= '0;
    end else if (s1_adv) begin
      last_quad_r <= quad;
      seen_r      <= 1'b1;
      scr_r       <= scr_nxt;
      count_r     <= count_nxt;
      dfr_r       <= dfr_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && got;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && got) begin
      out_data_r <= got_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_bitcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dfr_r.in_frame |-> (dfr_r.bit_count <= DATA_BITS))
    else $error("deframer bit count out of range");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r >= $past(count_r)))
    else $error("symbol count went backwards");

  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |=> seen_r)
    else $error("seen flag cleared without reset");

  a_byte_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && got) |=> (out_valid_r && out_data_r == $past(got_byte)))
    else $error("completed byte not presented");

  a_warmup_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !enable) |=> (dfr_r == $past(dfr_r)))
    else $error("deframer moved while disabled");

endmodule
